### rtl/core/cpt_pkg.sv
// Shared constants for the closest-point-on-triangle pipeline.
`timescale 1ns / 1ps
package cpt_pkg;
	localparam int COORD_BITS_DEF       = 20;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;
	localparam int DOT_BITS_DEF         = 2 * (COORD_BITS_DEF + 1) + 2;
	localparam int RATIO_BITS_DEF       = 2 * DOT_BITS_DEF + 1;
endpackage

### rtl/core/cpt_wmul.sv
// Two-stage signed wide multiplier built from four registered partial products.
`timescale 1ns / 1ps
module cpt_wmul #(
	parameter int DW = cpt_pkg::DOT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [DW-1:0]   x,
	input  logic signed [DW-1:0]   y,
	output logic signed [2*DW-1:0] p
);
	localparam int L  = DW / 2;
	localparam int H  = DW - L;
	localparam int PW = 2 * DW;

	logic signed [L:0]     xl, yl;
	logic signed [H-1:0]   xh, yh;
	logic signed [2*L+1:0] ll_q;
	logic signed [L+H:0]   lh_q, hl_q;
	logic signed [2*H-1:0] hh_q;

	assign xl = $signed({1'b0, x[L-1:0]});
	assign yl = $signed({1'b0, y[L-1:0]});
	assign xh = x[DW-1:L];
	assign yh = y[DW-1:L];

	always_ff @(posedge clk) begin
		if (en) begin
			ll_q <= xl * yl;
			lh_q <= xl * yh;
			hl_q <= xh * yl;
			hh_q <= xh * yh;
			p    <= (PW'(hh_q) <<< (2 * L)) + ((PW'(lh_q) + PW'(hl_q)) <<< L) + PW'(ll_q);
		end
	end
endmodule

### rtl/core/cpt_ratio.sv
// Pipelined clamped fraction unit: one quotient bit per stage.
`timescale 1ns / 1ps
module cpt_ratio #(
	parameter int NW = cpt_pkg::RATIO_BITS_DEF,
	parameter int WF = cpt_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic [WF:0]          quo
);
	localparam int RW = NW + 1;
	localparam logic [WF:0] ONE = {1'b1, {WF{1'b0}}};

	logic [RW-1:0] rem_q  [WF+1];
	logic [RW-1:0] den_q  [WF+1];
	logic [WF-1:0] bits_q [WF+1];
	logic          zero_q [WF+1];
	logic          full_q [WF+1];

	always_ff @(posedge clk) begin
		logic [RW-1:0] r2;
		if (en) begin
			zero_q[0] <= num[NW-1] || (num == '0) || den[NW-1] || (den == '0);
			full_q[0] <= num >= den;
			rem_q[0]  <= RW'($unsigned(num));
			den_q[0]  <= RW'($unsigned(den));
			bits_q[0] <= '0;
			for (int k = 1; k <= WF; k++) begin
				r2 = rem_q[k-1] << 1;
				if (r2 >= den_q[k-1]) begin
					rem_q[k]  <= r2 - den_q[k-1];
					bits_q[k] <= {bits_q[k-1][WF-2:0], 1'b1};
				end else begin
					rem_q[k]  <= r2;
					bits_q[k] <= {bits_q[k-1][WF-2:0], 1'b0};
				end
				den_q[k]  <= den_q[k-1];
				zero_q[k] <= zero_q[k-1];
				full_q[k] <= full_q[k-1];
			end
		end
	end

	always_comb begin
		priority if (zero_q[WF]) begin
			quo = '0;
		end else if (full_q[WF]) begin
			quo = ONE;
		end else begin
			quo = {1'b0, bits_q[WF]};
		end
	end
endmodule

### rtl/core/closest_point_on_triangle.sv
// Top level: streaming closest point on a triangle with barycentric weights.
//
// Input channel: in_valid/in_stall with vertices a, b, c and query point q,
// signed fixed point. A beat is taken when in_valid is high and in_stall low.
// Output channel: out_valid/out_stall with the closest point near_*, the
// weights s_weight and t_weight (unsigned Q1.WEIGHT_FRAC_BITS) and the degenerate flag.
// One result beat per input beat, in order.
// The pipeline holds seven stages of dot products, wide products and region
// select, one divider stage per weight bit plus one setup stage, then
// weighting, summing and the output register. It takes one beat per cycle
// while out_stall does not hold a full output register.
// Reset clears all valid bits; payload registers are not reset.
// When out_stall holds a full output register, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
module closest_point_on_triangle #(
	parameter int COORD_BITS       = cpt_pkg::COORD_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = cpt_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	input  logic signed [COORD_BITS-1:0] q_x,
	input  logic signed [COORD_BITS-1:0] q_y,
	input  logic signed [COORD_BITS-1:0] q_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] near_x,
	output logic signed [COORD_BITS-1:0] near_y,
	output logic signed [COORD_BITS-1:0] near_z,
	output logic [WEIGHT_FRAC_BITS:0]    s_weight,
	output logic [WEIGHT_FRAC_BITS:0]    t_weight,
	output logic                         degenerate
);
	localparam int CB  = COORD_BITS;
	localparam int WF  = WEIGHT_FRAC_BITS;
	localparam int DF  = CB + 1;
	localparam int PR  = 2 * DF;
	localparam int DW  = PR + 2;
	localparam int NW  = 2 * DW + 1;
	localparam int GD  = WF + 7;
	localparam int NST = WF + 11;
	localparam int SW  = WF + DF + 2;
	localparam int AW  = CB + WF + 3;
	localparam logic [WF:0]   ONE  = {1'b1, {WF{1'b0}}};
	localparam logic [AW-1:0] HALF = AW'(ONE >> 1);

	typedef struct packed {
		logic signed [2:0][DF-1:0] va;
		logic signed [2:0][DF-1:0] e0;
		logic signed [2:0][DF-1:0] e1;
	} geo_t;

	typedef struct packed {
		logic comp;
		logic degen;
	} side_t;

	logic adv;
	logic [NST-1:0] vld_q;

	logic signed [CB-1:0] av [3], bv [3], cv [3], qv [3];

	logic signed [DF-1:0] va_s1 [3], e0_s1 [3], e1_s1 [3], vq_s1 [3];
	logic signed [PR-1:0] pa_s2 [3], pb_s2 [3], pc_s2 [3], pd_s2 [3], pe_s2 [3];
	logic signed [DW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;
	logic signed [DW-1:0] a_s4, b_s4, c_s4, d_s4, e_s4;
	logic signed [DW-1:0] a_s5, b_s5, c_s5, d_s5, e_s5;
	logic signed [2*DW-1:0] ac_s5, bb_s5, be_s5, cd_s5, bd_s5, ae_s5;
	logic signed [NW-1:0] det_s6, sn_s6, tn_s6, den_s6, far_s6, nd_s6, ne_s6, a_s6, c_s6;
	logic                 bdce_s6, bead_s6, dneg_s6;
	logic signed [NW-1:0] ns_s7, ds_s7, nt_s7, dt_s7;
	logic signed [NW-1:0] ns_c, ds_c, nt_c, dt_c;
	logic                 comp_c, degen_c;
	side_t                side_s7;
	side_t                side_q [WF+1];
	geo_t                 geo_q [GD];
	logic [WF:0]          qs, qt;
	logic [WF:0]          s_sf1, t_sf1;
	geo_t                 geo_sf1;
	logic                 degen_sf1;
	logic signed [SW-1:0] ps_sf2 [3], pt_sf2 [3];
	logic signed [DF-1:0] va_sf2 [3];
	logic [WF:0]          s_sf2, t_sf2;
	logic                 degen_sf2;
	logic signed [CB-1:0] near_q [3];
	logic [WF:0]          s_q, t_q;
	logic                 degen_q;
	logic signed [NW:0]   snt;
	logic                 sum_lt;
	geo_t                 geo_in;

	assign av[0] = a_x; assign av[1] = a_y; assign av[2] = a_z;
	assign bv[0] = b_x; assign bv[1] = b_y; assign bv[2] = b_z;
	assign cv[0] = c_x; assign cv[1] = c_y; assign cv[2] = c_z;
	assign qv[0] = q_x; assign qv[1] = q_y; assign qv[2] = q_z;

	assign adv      = !vld_q[NST-1] || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				va_s1[i] <= DF'(av[i]);
				e0_s1[i] <= DF'(bv[i]) - DF'(av[i]);
				e1_s1[i] <= DF'(cv[i]) - DF'(av[i]);
				vq_s1[i] <= DF'(av[i]) - DF'(qv[i]);
				pa_s2[i] <= e0_s1[i] * e0_s1[i];
				pb_s2[i] <= e0_s1[i] * e1_s1[i];
				pc_s2[i] <= e1_s1[i] * e1_s1[i];
				pd_s2[i] <= e0_s1[i] * vq_s1[i];
				pe_s2[i] <= e1_s1[i] * vq_s1[i];
			end
			a_s3 <= DW'(pa_s2[0]) + DW'(pa_s2[1]) + DW'(pa_s2[2]);
			b_s3 <= DW'(pb_s2[0]) + DW'(pb_s2[1]) + DW'(pb_s2[2]);
			c_s3 <= DW'(pc_s2[0]) + DW'(pc_s2[1]) + DW'(pc_s2[2]);
			d_s3 <= DW'(pd_s2[0]) + DW'(pd_s2[1]) + DW'(pd_s2[2]);
			e_s3 <= DW'(pe_s2[0]) + DW'(pe_s2[1]) + DW'(pe_s2[2]);
			a_s4 <= a_s3; b_s4 <= b_s3; c_s4 <= c_s3; d_s4 <= d_s3; e_s4 <= e_s3;
			a_s5 <= a_s4; b_s5 <= b_s4; c_s5 <= c_s4; d_s5 <= d_s4; e_s5 <= e_s4;
		end
	end

	cpt_wmul #(.DW(DW)) u_ac (.clk(clk), .en(adv), .x(a_s3), .y(c_s3), .p(ac_s5));
	cpt_wmul #(.DW(DW)) u_bb (.clk(clk), .en(adv), .x(b_s3), .y(b_s3), .p(bb_s5));
	cpt_wmul #(.DW(DW)) u_be (.clk(clk), .en(adv), .x(b_s3), .y(e_s3), .p(be_s5));
	cpt_wmul #(.DW(DW)) u_cd (.clk(clk), .en(adv), .x(c_s3), .y(d_s3), .p(cd_s5));
	cpt_wmul #(.DW(DW)) u_bd (.clk(clk), .en(adv), .x(b_s3), .y(d_s3), .p(bd_s5));
	cpt_wmul #(.DW(DW)) u_ae (.clk(clk), .en(adv), .x(a_s3), .y(e_s3), .p(ae_s5));

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s6  <= NW'(ac_s5) - NW'(bb_s5);
			sn_s6   <= NW'(be_s5) - NW'(cd_s5);
			tn_s6   <= NW'(bd_s5) - NW'(ae_s5);
			den_s6  <= NW'(a_s5) - (NW'(b_s5) <<< 1) + NW'(c_s5);
			far_s6  <= NW'(c_s5) + NW'(e_s5) - NW'(b_s5) - NW'(d_s5);
			bdce_s6 <= (NW'(b_s5) + NW'(d_s5)) < (NW'(c_s5) + NW'(e_s5));
			bead_s6 <= (NW'(b_s5) + NW'(e_s5)) < (NW'(a_s5) + NW'(d_s5));
			nd_s6   <= -NW'(d_s5);
			ne_s6   <= -NW'(e_s5);
			a_s6    <= NW'(a_s5);
			c_s6    <= NW'(c_s5);
			dneg_s6 <= d_s5[DW-1];
		end
	end

	assign snt    = (NW+1)'(sn_s6) + (NW+1)'(tn_s6);
	assign sum_lt = snt < (NW+1)'(det_s6);

	always_comb begin
		ns_c    = '0;
		ds_c    = '0;
		nt_c    = '0;
		dt_c    = '0;
		comp_c  = 1'b0;
		degen_c = det_s6[NW-1] || (det_s6 == '0);
		priority if (degen_c) begin
			comp_c = 1'b0;
		end else if (sum_lt) begin
			if (sn_s6[NW-1]) begin
				if (tn_s6[NW-1] && dneg_s6) begin
					ns_c = nd_s6; ds_c = a_s6;
				end else begin
					nt_c = ne_s6; dt_c = c_s6;
				end
			end else if (tn_s6[NW-1]) begin
				ns_c = nd_s6; ds_c = a_s6;
			end else begin
				ns_c = sn_s6; ds_c = det_s6;
				nt_c = tn_s6; dt_c = det_s6;
			end
		end else begin
			if (sn_s6[NW-1]) begin
				if (bdce_s6) begin
					ns_c = far_s6; ds_c = den_s6; comp_c = 1'b1;
				end else begin
					nt_c = ne_s6; dt_c = c_s6;
				end
			end else if (tn_s6[NW-1]) begin
				if (bead_s6) begin
					ns_c = far_s6; ds_c = den_s6; comp_c = 1'b1;
				end else begin
					ns_c = nd_s6; ds_c = a_s6;
				end
			end else begin
				ns_c = far_s6; ds_c = den_s6; comp_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ns_s7         <= ns_c;
			ds_s7         <= ds_c;
			nt_s7         <= nt_c;
			dt_s7         <= dt_c;
			side_s7.comp  <= comp_c;
			side_s7.degen <= degen_c;
		end
	end

	cpt_ratio #(.NW(NW), .WF(WF)) u_rs (
		.clk(clk), .en(adv), .num(ns_s7), .den(ds_s7), .quo(qs)
	);
	cpt_ratio #(.NW(NW), .WF(WF)) u_rt (
		.clk(clk), .en(adv), .num(nt_s7), .den(dt_s7), .quo(qt)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geo_in.va[i] = va_s1[i];
			geo_in.e0[i] = e0_s1[i];
			geo_in.e1[i] = e1_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_q[0] <= geo_in;
			for (int k = 1; k < GD; k++) begin
				geo_q[k] <= geo_q[k-1];
			end
			side_q[0] <= side_s7;
			for (int k = 1; k <= WF; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_sf1     <= qs;
			t_sf1     <= side_q[WF].comp ? ONE - qs : qt;
			geo_sf1   <= geo_q[GD-1];
			degen_sf1 <= side_q[WF].degen;
			for (int i = 0; i < 3; i++) begin
				ps_sf2[i] <= $signed({1'b0, s_sf1}) * $signed(geo_sf1.e0[i]);
				pt_sf2[i] <= $signed({1'b0, t_sf1}) * $signed(geo_sf1.e1[i]);
				va_sf2[i] <= geo_sf1.va[i];
			end
			s_sf2     <= s_sf1;
			t_sf2     <= t_sf1;
			degen_sf2 <= degen_sf1;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [AW-1:0] acc;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				acc = (AW'(va_sf2[i]) <<< WF) + AW'(ps_sf2[i]) + AW'(pt_sf2[i])
					+ $signed(HALF);
				near_q[i] <= acc[WF +: CB];
			end
			s_q     <= s_sf2;
			t_q     <= t_sf2;
			degen_q <= degen_sf2;
		end
	end

	assign out_valid  = vld_q[NST-1];
	assign near_x     = near_q[0];
	assign near_y     = near_q[1];
	assign near_z     = near_q[2];
	assign s_weight   = s_q;
	assign t_weight   = t_q;
	assign degenerate = degen_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> s_weight == '0 && t_weight == '0)
		else $error("degenerate beat with nonzero weights");

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((WF+2)'(s_weight) + (WF+2)'(t_weight)) <= (WF+2)'(ONE))
		else $error("weights sum above one");

	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall out of step with output register");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vld_q))
		else $error("pipeline moved under stall");
endmodule
